// ===== design/rtnh_pkg.sv =====
package rtnh_pkg;

	// coordinate and result widths
	localparam int CB        = 32;
	localparam int IB        = 16;
	localparam int FRAC      = 16;
	localparam int DB        = 31;
	localparam int EPS_RESET = 7;

	// derived widths of the datapath
	localparam int MB     = CB + 1;          // edge, offset and multiplier width
	localparam int PW     = 2 * CB + 3;      // cross product width
	localparam int ACC_W  = 3 * CB + 6;      // dot product and accumulator width
	localparam int DIV_W  = ACC_W + DB;      // divider remainder width
	localparam int SAT_W  = ACC_W + DB - FRAC;
	localparam int EPS_SH = 2 * FRAC;
	localparam int MB_CW  = $clog2(MB);
	localparam int DB_CW  = $clog2(DB);

	// configuration register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_X    = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y    = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_Z    = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DIRECTION_X = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DIRECTION_Y = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_DIRECTION_Z = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_DET_EPSILON = 3'd6;

	typedef logic [2:0][CB-1:0] coord3_t;
	typedef logic [2:0][MB-1:0] evec_t;

	typedef struct packed {
		logic signed [CB-1:0] a_x;
		logic signed [CB-1:0] a_y;
		logic signed [CB-1:0] a_z;
		logic signed [CB-1:0] b_x;
		logic signed [CB-1:0] b_y;
		logic signed [CB-1:0] b_z;
		logic signed [CB-1:0] c_x;
		logic signed [CB-1:0] c_y;
		logic signed [CB-1:0] c_z;
		logic [IB-1:0]        tri_index;
		logic                 last_tri;
	} item_t;

	typedef struct packed {
		logic          hit;
		logic [DB-1:0] distance;
		logic [IB-1:0] hit_index;
	} result_t;

	// triangle after the front: edges and origin offset
	typedef struct packed {
		evec_t         e0;
		evec_t         e1;
		evec_t         s;
		logic [IB-1:0] tri_index;
		logic          last_tri;
	} mid_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	localparam int MID_W = $bits(mid_t);
	localparam int RES_W = $bits(result_t);

	// next component of a 3-vector, cyclic
	function automatic logic [1:0] nxt3(input logic [1:0] c);
		logic [1:0] r;
		r = (c == 2'd2) ? 2'd0 : 2'(c + 2'd1);
		return r;
	endfunction

endpackage

// ===== design/ray_triangle_nearest_hit_top.sv =====
// Nearest ray-triangle hit unit (Moller-Trumbore, exact fixed point).
// The ray (origin, direction) and the det epsilon are written through the
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while the unit is
// idle; cfg_ready is always high. Triangles enter as beats on the item
// queue (push/full). Each one is tested against the ray and the nearest hit
// is kept; on the beat marked last_tri one result beat (hit, distance,
// hit_index) goes to the result queue (empty/pop) and the tracker clears.
// Each triangle runs 24 exact products on one shared shift-add multiplier,
// then sign normalize, the hit tests and a restoring divider for the
// distance. A front stage and a two-beat queue hold up to three further
// triangles meanwhile. The divider is skipped when the triangle misses
// or its distance saturates.
// A stalled result queue (two beats deep) holds the back end in its output
// step; the front keeps taking triangles until its queue fills.
// Reset clears the ray to zero, the epsilon to 7 and all queues.
module ray_triangle_nearest_hit_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  rtnh_pkg::item_t                 item,
	output logic                            empty,
	input  logic                            pop,
	output rtnh_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rtnh_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [rtnh_pkg::CB-1:0]         cfg_data
);

	rtnh_pkg::coord3_t      org_q, dir_q;
	logic [rtnh_pkg::DB-1:0] eps_q;

	logic                 mid_push, mid_wr, mid_pop;
	rtnh_pkg::mid_t       mid_in, mid_out;
	rtnh_pkg::fifo_stat_t mid_stat, res_stat;
	logic                 res_push;
	rtnh_pkg::result_t    res_in;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0;
			dir_q <= '0;
			eps_q <= rtnh_pkg::DB'(rtnh_pkg::EPS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rtnh_pkg::CFG_ORIGIN_X:    org_q[0] <= cfg_data;
				rtnh_pkg::CFG_ORIGIN_Y:    org_q[1] <= cfg_data;
				rtnh_pkg::CFG_ORIGIN_Z:    org_q[2] <= cfg_data;
				rtnh_pkg::CFG_DIRECTION_X: dir_q[0] <= cfg_data;
				rtnh_pkg::CFG_DIRECTION_Y: dir_q[1] <= cfg_data;
				rtnh_pkg::CFG_DIRECTION_Z: dir_q[2] <= cfg_data;
				rtnh_pkg::CFG_DET_EPSILON: eps_q    <= cfg_data[rtnh_pkg::DB-1:0];
				default: ;
			endcase
		end
	end

	// front: edge setup
	rtnh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.org      (org_q),
		.mid_push (mid_push),
		.mid_full (mid_stat.full),
		.mid_data (mid_in)
	);

	assign mid_wr = mid_push && !mid_stat.full;

	// queue between front and back
	rtnh_fifo #(.WIDTH(rtnh_pkg::MID_W)) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_in),
		.rd_en   (mid_pop),
		.rd_data (mid_out),
		.stat    (mid_stat)
	);

	// back: products, tests, divide and nearest tracking
	rtnh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (!mid_stat.empty),
		.mid_data  (mid_out),
		.mid_pop   (mid_pop),
		.dir       (dir_q),
		.eps       (eps_q),
		.res_full  (res_stat.full),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	// result queue
	rtnh_fifo #(.WIDTH(rtnh_pkg::RES_W)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop && !empty),
		.rd_data (result),
		.stat    (res_stat)
	);

	assign empty = res_stat.empty;

	// checks
	a_mid_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_stat.empty)
		else $error("back end popped an empty queue");

	a_res_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_stat.full)
		else $error("result written into a full queue");

	a_res_visible: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("written result not visible");

endmodule

// ===== design/rtnh_fifo.sv =====
module rtnh_fifo #(
	parameter int WIDTH = rtnh_pkg::MID_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [WIDTH-1:0]    wr_data,
	input  logic                rd_en,
	output logic [WIDTH-1:0]    rd_data,
	output rtnh_pkg::fifo_stat_t stat
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= 2'(cnt_q + {1'b0, wr_en} - {1'b0, rd_en});
		end
	end

	assign rd_data    = mem_q[rp_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

endmodule

// ===== design/rtnh_front.sv =====
module rtnh_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rtnh_pkg::item_t  item,
	output logic             full,
	input  rtnh_pkg::coord3_t org,
	output logic             mid_push,
	input  logic             mid_full,
	output rtnh_pkg::mid_t   mid_data
);

	logic           valid_s1;
	rtnh_pkg::mid_t data_s1;
	rtnh_pkg::mid_t calc;
	logic           advance;

	// edges and origin offset, sign extended by one bit
	always_comb begin
		calc.e0[0] = rtnh_pkg::MB'($signed(item.b_x)) - rtnh_pkg::MB'($signed(item.a_x));
		calc.e0[1] = rtnh_pkg::MB'($signed(item.b_y)) - rtnh_pkg::MB'($signed(item.a_y));
		calc.e0[2] = rtnh_pkg::MB'($signed(item.b_z)) - rtnh_pkg::MB'($signed(item.a_z));
		calc.e1[0] = rtnh_pkg::MB'($signed(item.c_x)) - rtnh_pkg::MB'($signed(item.a_x));
		calc.e1[1] = rtnh_pkg::MB'($signed(item.c_y)) - rtnh_pkg::MB'($signed(item.a_y));
		calc.e1[2] = rtnh_pkg::MB'($signed(item.c_z)) - rtnh_pkg::MB'($signed(item.a_z));
		calc.s[0]  = rtnh_pkg::MB'($signed(org[0])) - rtnh_pkg::MB'($signed(item.a_x));
		calc.s[1]  = rtnh_pkg::MB'($signed(org[1])) - rtnh_pkg::MB'($signed(item.a_y));
		calc.s[2]  = rtnh_pkg::MB'($signed(org[2])) - rtnh_pkg::MB'($signed(item.a_z));
		calc.tri_index = item.tri_index;
		calc.last_tri  = item.last_tri;
	end

	// stage moves when empty or when the queue takes its beat
	assign advance  = !valid_s1 || !mid_full;
	assign full     = !advance;
	assign mid_push = valid_s1;
	assign mid_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && advance) begin
			data_s1 <= calc;
		end
	end

endmodule

// ===== design/rtnh_back.sv =====
module rtnh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mid_valid,
	input  rtnh_pkg::mid_t      mid_data,
	output logic                mid_pop,
	input  rtnh_pkg::coord3_t   dir,
	input  logic [rtnh_pkg::DB-1:0] eps,
	input  logic                res_full,
	output logic                res_push,
	output rtnh_pkg::result_t   res_data
);

	localparam int MB    = rtnh_pkg::MB;
	localparam int PW    = rtnh_pkg::PW;
	localparam int ACC_W = rtnh_pkg::ACC_W;
	localparam int DIV_W = rtnh_pkg::DIV_W;
	localparam int SAT_W = rtnh_pkg::SAT_W;
	localparam int DB    = rtnh_pkg::DB;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_NORM = 3'd3;
	localparam logic [2:0] ST_TEST = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_UPD  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	// result registers written by the multiply sequence
	localparam logic [3:0] R_P0  = 4'd0;
	localparam logic [3:0] R_P1  = 4'd1;
	localparam logic [3:0] R_P2  = 4'd2;
	localparam logic [3:0] R_Q0  = 4'd3;
	localparam logic [3:0] R_Q1  = 4'd4;
	localparam logic [3:0] R_Q2  = 4'd5;
	localparam logic [3:0] R_DET = 4'd6;
	localparam logic [3:0] R_UN  = 4'd7;
	localparam logic [3:0] R_VN  = 4'd8;
	localparam logic [3:0] R_TN  = 4'd9;

	logic [2:0]                 st_q;
	rtnh_pkg::evec_t            e0_q, e1_q, s_q;
	logic [rtnh_pkg::IB-1:0]    idx_q;
	logic                       last_q;
	logic [2:0][PW-1:0]         p_q, q_q;
	logic [ACC_W-1:0]           det_q, un_q, vn_q, tn_q;
	logic [3:0]                 res_q;
	logic [1:0]                 term_q;
	logic [rtnh_pkg::MB_CW-1:0] bit_q;
	logic [ACC_W-1:0]           acc_q, mcand_q;
	logic [MB-1:0]              mplier_q;
	logic [DIV_W-1:0]           rem_q, dsh_q;
	logic [DB-1:0]              quo_q;
	logic [rtnh_pkg::DB_CW-1:0] dbit_q;
	logic                       found_q;
	logic                       have_best_q;
	logic [DB-1:0]              best_dist_q;
	logic [rtnh_pkg::IB-1:0]    best_idx_q;

	rtnh_pkg::evec_t  dir_e;
	logic [1:0]       cc, i1, i2, xi, yi;
	logic             is_cross, last_term, neg_now;
	logic [MB-1:0]    mpl;
	logic [ACC_W-1:0] mcd, addend, acc_next;

	// direction widened to the edge width
	always_comb begin
		dir_e[0] = MB'($signed(dir[0]));
		dir_e[1] = MB'($signed(dir[1]));
		dir_e[2] = MB'($signed(dir[2]));
	end

	// operand select for the current term
	always_comb begin
		is_cross = (res_q <= R_Q2);
		cc       = (res_q < R_Q0) ? res_q[1:0] : 2'(res_q - R_Q0);
		i1       = rtnh_pkg::nxt3(cc);
		i2       = rtnh_pkg::nxt3(i1);
		xi       = (term_q == 2'd0) ? i1 : i2;
		yi       = (term_q == 2'd0) ? i2 : i1;
		mpl      = '0;
		mcd      = '0;
		unique case (res_q)
			R_P0, R_P1, R_P2: begin
				mpl = dir_e[xi];
				mcd = ACC_W'($signed(e1_q[yi]));
			end
			R_Q0, R_Q1, R_Q2: begin
				mpl = s_q[xi];
				mcd = ACC_W'($signed(e0_q[yi]));
			end
			R_DET: begin
				mpl = e0_q[term_q];
				mcd = ACC_W'($signed(p_q[term_q]));
			end
			R_UN: begin
				mpl = s_q[term_q];
				mcd = ACC_W'($signed(p_q[term_q]));
			end
			R_VN: begin
				mpl = dir_e[term_q];
				mcd = ACC_W'($signed(q_q[term_q]));
			end
			R_TN: begin
				mpl = e1_q[term_q];
				mcd = ACC_W'($signed(q_q[term_q]));
			end
			default: begin
				mpl = '0;
				mcd = '0;
			end
		endcase
		last_term = is_cross ? (term_q == 2'd1) : (term_q == 2'd2);
	end

	// shift-add step, sign bit of the multiplier has negative weight, second cross term is subtracted
	always_comb begin
		neg_now  = (is_cross && term_q == 2'd1) ^ (bit_q == rtnh_pkg::MB_CW'(MB - 1));
		addend   = mplier_q[0] ? (neg_now ? ~mcand_q : mcand_q) : '0;
		acc_next = acc_q + addend + ACC_W'(mplier_q[0] & neg_now);
	end

	// hit tests on the normalized numerators
	logic             det_zero, below_eps, un_gt, uv_gt, miss, sat, ge;
	logic [ACC_W:0]   uv_sum;
	always_comb begin
		det_zero  = (det_q == '0);
		below_eps = (det_q[ACC_W-1:rtnh_pkg::EPS_SH] <
			(ACC_W - rtnh_pkg::EPS_SH)'(eps));
		un_gt     = ($signed(un_q) > $signed(det_q));
		uv_sum    = (ACC_W + 1)'($signed(un_q)) + (ACC_W + 1)'($signed(vn_q));
		uv_gt     = ($signed(uv_sum) > $signed((ACC_W + 1)'($signed(det_q))));
		miss      = det_zero || below_eps || un_q[ACC_W-1] || un_gt ||
			vn_q[ACC_W-1] || uv_gt || tn_q[ACC_W-1];
		sat       = (SAT_W'(tn_q) >= (SAT_W'(det_q) << (DB - rtnh_pkg::FRAC)));
		ge        = (rem_q >= dsh_q);
	end

	assign mid_pop  = (st_q == ST_IDLE) && mid_valid;
	assign res_push = (st_q == ST_OUT) && !res_full;
	assign res_data = '{hit: have_best_q, distance: best_dist_q, hit_index: best_idx_q};

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			res_q       <= R_P0;
			term_q      <= 2'd0;
			bit_q       <= '0;
			dbit_q      <= '0;
			have_best_q <= 1'b0;
			best_dist_q <= '0;
			best_idx_q  <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (mid_valid) begin
						res_q  <= R_P0;
						term_q <= 2'd0;
						st_q   <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					bit_q <= '0;
					st_q  <= ST_MUL;
				end
				ST_MUL: begin
					bit_q <= rtnh_pkg::MB_CW'(bit_q + 1'b1);
					if (bit_q == rtnh_pkg::MB_CW'(MB - 1)) begin
						if (last_term) begin
							term_q <= 2'd0;
							if (res_q == R_TN) begin
								st_q <= ST_NORM;
							end else begin
								res_q <= 4'(res_q + 4'd1);
								st_q  <= ST_LOAD;
							end
						end else begin
							term_q <= 2'(term_q + 2'd1);
							st_q   <= ST_LOAD;
						end
					end
				end
				ST_NORM: st_q <= ST_TEST;
				ST_TEST: begin
					dbit_q <= '0;
					st_q   <= (miss || sat) ? ST_UPD : ST_DIV;
				end
				ST_DIV: begin
					dbit_q <= rtnh_pkg::DB_CW'(dbit_q + 1'b1);
					if (dbit_q == rtnh_pkg::DB_CW'(DB - 1)) st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (found_q && (!have_best_q || quo_q < best_dist_q)) begin
						have_best_q <= 1'b1;
						best_dist_q <= quo_q;
						best_idx_q  <= idx_q;
					end
					st_q <= last_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (!res_full) begin
						have_best_q <= 1'b0;
						best_dist_q <= '0;
						best_idx_q  <= '0;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (mid_valid) begin
					e0_q   <= mid_data.e0;
					e1_q   <= mid_data.e1;
					s_q    <= mid_data.s;
					idx_q  <= mid_data.tri_index;
					last_q <= mid_data.last_tri;
				end
			end
			ST_LOAD: begin
				mcand_q  <= mcd;
				mplier_q <= mpl;
				if (term_q == 2'd0) acc_q <= '0;
			end
			ST_MUL: begin
				acc_q    <= acc_next;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				if (bit_q == rtnh_pkg::MB_CW'(MB - 1) && last_term) begin
					unique case (res_q)
						R_P0, R_P1, R_P2: p_q[cc] <= acc_next[PW-1:0];
						R_Q0, R_Q1, R_Q2: q_q[cc] <= acc_next[PW-1:0];
						R_DET:            det_q   <= acc_next;
						R_UN:             un_q    <= acc_next;
						R_VN:             vn_q    <= acc_next;
						R_TN:             tn_q    <= acc_next;
						default: ;
					endcase
				end
			end
			ST_NORM: begin
				// flip signs so that the determinant is positive
				if (det_q[ACC_W-1]) begin
					det_q <= -det_q;
					un_q  <= -un_q;
					vn_q  <= -vn_q;
					tn_q  <= -tn_q;
				end
			end
			ST_TEST: begin
				found_q <= !miss;
				quo_q   <= sat ? '1 : '0;
				rem_q   <= DIV_W'(tn_q) << rtnh_pkg::FRAC;
				dsh_q   <= DIV_W'(det_q) << (DB - 1);
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (ge) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[DB-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/sv/rtnh_checker.sv =====
`timescale 1ns / 1ps

module rtnh_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        full,
	input  rtnh_pkg::item_t             item,
	input  logic                        empty,
	input  logic                        pop,
	input  rtnh_pkg::result_t           result,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [rtnh_pkg::CFG_IW-1:0] cfg_index,
	input  logic [rtnh_pkg::CB-1:0]     cfg_data,
	output int                          errors,
	output int                          pending,
	output int                          n_tris,
	output int                          n_queries,
	output int                          n_hits
);
	import rtnh_pkg::*;

	typedef logic signed [191:0] wide_t;

	// ray held by the checker
	logic signed [CB-1:0] org_x, org_y, org_z, dir_x, dir_y, dir_z;
	logic [DB-1:0]        eps;

	// nearest-hit tracker
	logic          best_valid;
	logic [DB-1:0] best_dist;
	logic [IB-1:0] best_idx;

	result_t query_q[$];

	// exact ray-triangle test, returns 1 on hit with the distance, saturated at its maximum
	function automatic logic tri_hit(input item_t t, output logic [DB-1:0] dist_o);
		wide_t e0x, e0y, e0z, e1x, e1y, e1z, sx, sy, sz;
		wide_t dx, dy, dz, px, py, pz, qx, qy, qz;
		wide_t det, un, vn, tn, num;
		dist_o = '0;
		dx = wide_t'(dir_x);
		dy = wide_t'(dir_y);
		dz = wide_t'(dir_z);
		e0x = wide_t'(t.b_x) - wide_t'(t.a_x);
		e0y = wide_t'(t.b_y) - wide_t'(t.a_y);
		e0z = wide_t'(t.b_z) - wide_t'(t.a_z);
		e1x = wide_t'(t.c_x) - wide_t'(t.a_x);
		e1y = wide_t'(t.c_y) - wide_t'(t.a_y);
		e1z = wide_t'(t.c_z) - wide_t'(t.a_z);
		sx = wide_t'(org_x) - wide_t'(t.a_x);
		sy = wide_t'(org_y) - wide_t'(t.a_y);
		sz = wide_t'(org_z) - wide_t'(t.a_z);
		px = dy * e1z - dz * e1y;
		py = dz * e1x - dx * e1z;
		pz = dx * e1y - dy * e1x;
		qx = sy * e0z - sz * e0y;
		qy = sz * e0x - sx * e0z;
		qz = sx * e0y - sy * e0x;
		det = e0x * px + e0y * py + e0z * pz;
		un = sx * px + sy * py + sz * pz;
		vn = dx * qx + dy * qy + dz * qz;
		tn = e1x * qx + e1y * qy + e1z * qz;
		if (det == 0)
			return 1'b0;
		if (det < 0) begin
			det = -det;
			un = -un;
			vn = -vn;
			tn = -tn;
		end
		if (det < (wide_t'({1'b0, eps}) <<< EPS_SH))
			return 1'b0;
		if (un < 0 || un > det || vn < 0 || un + vn > det || tn < 0)
			return 1'b0;
		num = tn <<< FRAC;
		if (num >= (det <<< DB))
			dist_o = {DB{1'b1}};
		else
			dist_o = DB'(num / det);
		return 1'b1;
	endfunction

	// watch the channels, predict and compare
	always @(posedge clk or negedge arst_n) begin
		logic [DB-1:0] d;
		result_t       r;
		if (!arst_n) begin
			org_x = '0; org_y = '0; org_z = '0;
			dir_x = '0; dir_y = '0; dir_z = '0;
			eps = DB'(EPS_RESET);
			best_valid = 1'b0;
			best_dist = '0;
			best_idx = '0;
			query_q.delete();
			errors = 0;
			n_tris = 0;
			n_queries = 0;
			n_hits = 0;
		end else begin
			// register write beat
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ORIGIN_X:    org_x = cfg_data;
					CFG_ORIGIN_Y:    org_y = cfg_data;
					CFG_ORIGIN_Z:    org_z = cfg_data;
					CFG_DIRECTION_X: dir_x = cfg_data;
					CFG_DIRECTION_Y: dir_y = cfg_data;
					CFG_DIRECTION_Z: dir_z = cfg_data;
					CFG_DET_EPSILON: eps = cfg_data[DB-1:0];
					default: ;
				endcase
			end
			// triangle beat
			if (push && !full) begin
				n_tris++;
				if (tri_hit(item, d) && (!best_valid || d < best_dist)) begin
					best_valid = 1'b1;
					best_dist = d;
					best_idx = item.tri_index;
				end
				if (item.last_tri) begin
					r.hit = best_valid;
					r.distance = best_valid ? best_dist : '0;
					r.hit_index = best_valid ? best_idx : '0;
					query_q.push_back(r);
					best_valid = 1'b0;
					best_dist = '0;
					best_idx = '0;
				end
			end
			// result beat
			if (pop && !empty) begin
				if (query_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %p", $time, result);
				end else begin
					r = query_q.pop_front();
					n_queries++;
					if (r.hit)
						n_hits++;
					if (result.hit !== r.hit) begin
						errors++;
						$display("%0t: hit expected %0d actual %0d", $time, r.hit, result.hit);
					end
					if (result.distance !== r.distance) begin
						errors++;
						$display("%0t: distance expected %0h actual %0h", $time,
							r.distance, result.distance);
					end
					if (result.hit_index !== r.hit_index) begin
						errors++;
						$display("%0t: hit_index expected %0d actual %0d", $time,
							r.hit_index, result.hit_index);
					end
				end
			end
		end
		pending = query_q.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import rtnh_pkg::*;

	localparam int ONE       = 65536;
	localparam int WDOG_MAX  = 20000;
	localparam int DRAIN_CYC = 900;
	localparam int HOLD_CYC  = 6000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	item_t               item = '0;
	logic                empty;
	logic                pop = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CB-1:0]       cfg_data = '0;

	int errors, pending, n_tris, n_queries, n_hits;
	int tx_idle = 22;
	int rx_idle = 73;
	int hold_cnt = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int wdog = 0;

	// ray as last written, for aiming triangles
	int ray_o[3];
	int ray_d[3];

	always #5 clk = ~clk;

	ray_triangle_nearest_hit_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rtnh_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .n_tris(n_tris),
		.n_queries(n_queries), .n_hits(n_hits)
	);

	// result side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			pop <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= HOLD_CYC;
			hold_done <= 1'b1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle);
		end
	end

	// watchdog on cycles with no beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CB-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tri(input item_t t);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// write the whole ray, the epsilon and an unused index
	task automatic set_ray(input int ox, input int oy, input int oz,
			input int dx, input int dy, input int dz, input int eps_val);
		ray_o[0] = ox; ray_o[1] = oy; ray_o[2] = oz;
		ray_d[0] = dx; ray_d[1] = dy; ray_d[2] = dz;
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_DIRECTION_X, dx);
		write_reg(CFG_DIRECTION_Y, dy);
		write_reg(CFG_DIRECTION_Z, dz);
		write_reg(CFG_DET_EPSILON, eps_val);
		write_reg(CFG_IW'(7), $urandom);
	endtask

	function automatic item_t mk_tri(input int ax, input int ay, input int az,
			input int bx, input int by, input int bz, input int cx, input int cy,
			input int cz, input int idx, input logic last);
		item_t t;
		t.a_x = ax; t.a_y = ay; t.a_z = az;
		t.b_x = bx; t.b_y = by; t.b_z = bz;
		t.c_x = cx; t.c_y = cy; t.c_z = cz;
		t.tri_index = IB'(idx);
		t.last_tri = last;
		return t;
	endfunction

	// triangle around a point on the ray, or plain noise
	function automatic item_t aimed_tri(input logic last);
		item_t t;
		longint ctr[3];
		int spread, m, k;
		int v[9];
		if ($urandom_range(99) < 15) begin
			t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, 16'($urandom), 1'b0};
		end else begin
			m = $urandom_range(40);
			spread = 1 << $urandom_range(22, 6);
			for (k = 0; k < 3; k++)
				ctr[k] = longint'(ray_o[k]) + longint'(m) * longint'(ray_d[k]);
			for (k = 0; k < 9; k++)
				v[k] = int'(ctr[k % 3]) + $signed($urandom_range(2 * spread)) - spread;
			t = mk_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
				$urandom, 1'b0);
		end
		t.last_tri = last;
		return t;
	endfunction

	initial begin
		int ph, n, qlen, e;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ray along +z from z = -5, no epsilon
		set_ray(0, 0, -5 * ONE, 0, 0, ONE, 0);
		send_tri(mk_tri(-ONE, -ONE, 0, 2 * ONE, -ONE, 0, -ONE, 2 * ONE, 0, 1, 1'b1));
		// zero determinant
		send_tri(mk_tri(ONE, ONE, 0, ONE, ONE, 0, ONE, ONE, 0, 2, 1'b1));
		// equal distance keeps the earlier triangle
		send_tri(mk_tri(-ONE, -ONE, 0, 2 * ONE, -ONE, 0, -ONE, 2 * ONE, 0, 10, 1'b0));
		send_tri(mk_tri(-ONE, -ONE, 0, -ONE, 2 * ONE, 0, 2 * ONE, -ONE, 0, 11, 1'b1));
		// nearer hit arriving later wins
		send_tri(mk_tri(-ONE, -ONE, 3 * ONE, 2 * ONE, -ONE, 3 * ONE, -ONE, 2 * ONE,
			3 * ONE, 20, 1'b0));
		send_tri(mk_tri(-ONE, -ONE, -ONE, 2 * ONE, -ONE, -ONE, -ONE, 2 * ONE, -ONE,
			21, 1'b1));
		// behind the origin
		send_tri(mk_tri(-ONE, -ONE, -10 * ONE, 2 * ONE, -ONE, -10 * ONE, -ONE, 2 * ONE,
			-10 * ONE, 30, 1'b1));
		// u beyond one, v below zero, u and v below zero, u plus v exactly one (a hit on the edge)
		send_tri(mk_tri(-5 * ONE, -ONE, 0, -3 * ONE, -ONE, 0, -5 * ONE, ONE, 0, 40, 1'b0));
		send_tri(mk_tri(-ONE, ONE, 0, ONE, ONE, 0, -ONE, 3 * ONE, 0, 41, 1'b0));
		send_tri(mk_tri(ONE, ONE, 0, 3 * ONE, ONE, 0, ONE, 3 * ONE, 0, 42, 1'b0));
		send_tri(mk_tri(-ONE, -ONE, 0, ONE, -ONE, 0, -ONE, ONE, 0, 16'hffff, 1'b1));
		// field extremes
		send_tri(mk_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			0, 1'b0));
		send_tri(mk_tri(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			16'hffff, 1'b1));
		wait_idle();

		// distance saturates with a tiny direction
		set_ray(0, 0, 0, 0, 0, 1, 7);
		send_tri(mk_tri(-ONE, -ONE, 32'h40000000, 2 * ONE, -ONE, 32'h40000000, -ONE,
			2 * ONE, 32'h40000000, 5, 1'b1));
		wait_idle();

		// random phases with changing idling
		for (ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				tx_idle = 73;
				rx_idle = 22;
			end else if (ph == 8) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			e = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 7 : $urandom_range(ONE);
			if (ph == 3)
				set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
					32'h7fffffff, 32'h80000000, 32'h7fffffff);
			else if (ph == 6)
				set_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
					32'h80000000, 32'h7fffffff, e);
			else
				set_ray($signed($urandom_range(1 << 21)) - (1 << 20),
					$signed($urandom_range(1 << 21)) - (1 << 20),
					$signed($urandom_range(1 << 21)) - (1 << 20),
					$signed($urandom_range(1 << 19)) - (1 << 18),
					$signed($urandom_range(1 << 19)) - (1 << 18),
					$signed($urandom_range(1 << 19)) - (1 << 18), e);
			if (ph == 9)
				hold_req <= 1'b1;
			n = 0;
			while (n < 45) begin
				qlen = $urandom_range(5, 1);
				repeat (qlen) begin
					qlen--;
					send_tri(aimed_tri(qlen == 0));
					n++;
				end
			end
			wait_idle();
		end

		// run summary ahead of the verdict
		$display("tb_top: %0d triangles in %0d queries checked, %0d queries with a hit",
			n_tris, n_queries, n_hits);
		$display("tb_top: directed misses, ties, saturation, extreme coordinates, %s",
			"random rays under stalls and one long result hold-off");
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rtnh_pkg.sv
design/rtnh_fifo.sv
design/rtnh_front.sv
design/rtnh_back.sv
design/ray_triangle_nearest_hit_top.sv
tb/sv/rtnh_checker.sv
tb/sv/tb_top.sv
